// ===== hw/rtl/brcs_pkg.sv =====
package brcs_pkg;

  localparam int SIDE_DEF    = 10;
  localparam int ACT_W       = 2;
  localparam int DATA_W      = 8;
  localparam int IDX_W       = 7;
  localparam int KIND_W      = 2;
  localparam int SUM_W       = 32;
  localparam int LAYER_SUM_W = 12;

  localparam logic [ACT_W-1:0] ACT_BYTE  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_FLUSH = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

  localparam logic [KIND_W-1:0] KIND_COL  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ROW  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_CELL = 2'd2;

  typedef struct packed {
    logic        [ACT_W-1:0]  action;
    logic signed [DATA_W-1:0] data_byte;
    logic        [IDX_W-1:0]  cell_index;
  } in_word_t;

  typedef struct packed {
    logic        [KIND_W-1:0] sum_kind;
    logic        [IDX_W-1:0]  sum_index;
    logic signed [SUM_W-1:0]  sum_value;
    logic                     last_of_run;
  } out_word_t;

endpackage

// ===== hw/rtl/block_row_column_sum_checksum.sv =====
// Row/column sum checksum over SIDE x SIDE layers of signed bytes.
//
// Input channel (in_valid_i / in_stall_o / in_word_i): one word per action.
//   Data bytes are placed row-major into the current layer. They are taken
//   one per cycle while input is not stalled; each updates its column sum,
//   row sum and running cell sum by a read-modify-write of three memories
//   with registered reads. The byte that completes a layer, and a flush,
//   make the block emit 2*SIDE words (column sums, then row sums), one per
//   cycle while the receiver does not stall; input is stalled meanwhile.
//   A cell read returns one word and stalls input while it is pending.
// Output channel (out_valid_o / out_stall_i / out_word_o): a registered
//   output stage plus one pending word held in the memory read register.
//   While the receiver stalls the output word holds, the emit sequence
//   pauses and new input words are stalled once a result is pending.
// Reset: all layer and cell sums read as zero (per-entry valid bits,
//   cleared at once), the layer position returns to cell 0, and no output
//   is pending. No clearing pass is needed.
module block_row_column_sum_checksum #(
  parameter int SIDE = brcs_pkg::SIDE_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  brcs_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output brcs_pkg::out_word_t out_word_o
);
  import brcs_pkg::*;

  localparam int CELLS = SIDE * SIDE;
  localparam int SW    = $clog2(SIDE);
  localparam int PW    = $clog2(CELLS);
  localparam int KW    = $clog2(2 * SIDE);
  localparam int XW    = ((PW > IDX_W) ? PW : IDX_W) + 1;

  localparam logic ST_RUN  = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic st_q, st_d;
  logic [PW-1:0] pos_q, pos_d;
  logic [SW-1:0] col_q, col_d, row_q, row_d;
  logic [KW-1:0] k_q, k_d;

  // byte stage
  logic s1_vld_q, s1_full_q;
  logic [SW-1:0] s1_col_q, s1_row_q;
  logic [PW-1:0] s1_pos_q;
  logic signed [DATA_W-1:0] s1_b_q;

  // pending word (data sits in the memory read registers)
  logic pend_q, pend_d;
  logic [KIND_W-1:0] pend_kind_q;
  logic [IDX_W-1:0] pend_idx_q;
  logic pend_last_q, pend_oob_q;

  logic out_vld_q;
  out_word_t out_q;

  logic in_acc, byte_acc, flush_acc, read_acc, move, emit_issue, k_last, k_is_col;
  logic [XW-1:0] idx_ext;
  logic idx_oob;

  // column memory
  logic [LAYER_SUM_W-1:0] col_mem [SIDE];
  logic [LAYER_SUM_W-1:0] col_rd_q, col_fwdd_q, col_val, col_wd;
  logic [SIDE-1:0] col_vb_q;
  logic col_vld_q, col_fwd_q, col_re, col_we, col_clr;
  logic [SW-1:0] col_ra;

  // row memory
  logic [LAYER_SUM_W-1:0] row_mem [SIDE];
  logic [LAYER_SUM_W-1:0] row_rd_q, row_fwdd_q, row_val, row_wd;
  logic [SIDE-1:0] row_vb_q;
  logic row_vld_q, row_fwd_q, row_re;
  logic [SW-1:0] row_ra;

  // cell memory
  logic [SUM_W-1:0] cell_mem [CELLS];
  logic [SUM_W-1:0] cell_rd_q, cell_fwdd_q, cell_val, cell_wd;
  logic [CELLS-1:0] cell_vb_q;
  logic cell_vld_q, cell_fwd_q, cell_re;
  logic [PW-1:0] cell_ra;

  logic [KW-1:0] k_row;
  logic [SUM_W-1:0] pend_value;

  assign in_stall_o = (st_q != ST_RUN) || pend_q || (s1_vld_q && s1_full_q);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign byte_acc   = in_acc && (in_word_i.action == ACT_BYTE);
  assign flush_acc  = in_acc && (in_word_i.action == ACT_FLUSH);
  assign read_acc   = in_acc && (in_word_i.action == ACT_READ);

  assign idx_ext = XW'(in_word_i.cell_index);
  assign idx_oob = idx_ext >= XW'(CELLS);

  assign move       = pend_q && (!out_vld_q || !out_stall_i);
  assign emit_issue = (st_q == ST_EMIT) && (!pend_q || move);
  assign k_last     = k_q == KW'(2 * SIDE - 1);
  assign k_is_col   = k_q < KW'(SIDE);
  assign k_row      = k_q - KW'(SIDE);

  // memory ports
  assign col_re  = byte_acc || emit_issue;
  assign col_ra  = (st_q == ST_EMIT) ? k_q[SW-1:0] : col_q;
  assign row_re  = byte_acc || emit_issue;
  assign row_ra  = (st_q == ST_EMIT) ? k_row[SW-1:0] : row_q;
  assign cell_re = byte_acc || read_acc;
  assign cell_ra = read_acc ? idx_ext[PW-1:0] : pos_q;
  assign col_we  = s1_vld_q;
  assign col_clr = emit_issue && k_last;

  assign col_val  = !col_vld_q ? '0 : (col_fwd_q ? col_fwdd_q : col_rd_q);
  assign row_val  = !row_vld_q ? '0 : (row_fwd_q ? row_fwdd_q : row_rd_q);
  assign cell_val = !cell_vld_q ? '0 : (cell_fwd_q ? cell_fwdd_q : cell_rd_q);

  assign col_wd  = col_val + {{(LAYER_SUM_W-DATA_W){s1_b_q[DATA_W-1]}}, s1_b_q};
  assign row_wd  = row_val + {{(LAYER_SUM_W-DATA_W){s1_b_q[DATA_W-1]}}, s1_b_q};
  assign cell_wd = cell_val + {{(SUM_W-DATA_W){s1_b_q[DATA_W-1]}}, s1_b_q};

  always_ff @(posedge clk_i) begin
    if (col_we) col_mem[s1_col_q] <= col_wd;
    if (col_re) col_rd_q <= col_mem[col_ra];
    if (col_re) col_fwdd_q <= col_wd;
    if (col_we) row_mem[s1_row_q] <= row_wd;
    if (row_re) row_rd_q <= row_mem[row_ra];
    if (row_re) row_fwdd_q <= row_wd;
    if (col_we) cell_mem[s1_pos_q] <= cell_wd;
    if (cell_re) cell_rd_q <= cell_mem[cell_ra];
    if (cell_re) cell_fwdd_q <= cell_wd;
  end

  // valid bits and write-during-read forwarding
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_vb_q   <= '0;
      row_vb_q   <= '0;
      cell_vb_q  <= '0;
      col_vld_q  <= 1'b0;
      col_fwd_q  <= 1'b0;
      row_vld_q  <= 1'b0;
      row_fwd_q  <= 1'b0;
      cell_vld_q <= 1'b0;
      cell_fwd_q <= 1'b0;
    end else begin
      if (col_clr) begin
        col_vb_q <= '0;
        row_vb_q <= '0;
      end else if (col_we) begin
        col_vb_q[s1_col_q] <= 1'b1;
        row_vb_q[s1_row_q] <= 1'b1;
      end
      if (col_we) cell_vb_q[s1_pos_q] <= 1'b1;
      if (col_re) begin
        col_fwd_q <= col_we && (s1_col_q == col_ra);
        col_vld_q <= col_vb_q[col_ra] || (col_we && (s1_col_q == col_ra));
      end
      if (row_re) begin
        row_fwd_q <= col_we && (s1_row_q == row_ra);
        row_vld_q <= row_vb_q[row_ra] || (col_we && (s1_row_q == row_ra));
      end
      if (cell_re) begin
        cell_fwd_q <= col_we && (s1_pos_q == cell_ra);
        cell_vld_q <= cell_vb_q[cell_ra] || (col_we && (s1_pos_q == cell_ra));
      end
    end
  end

  // layer position and sequencing
  always_comb begin
    st_d  = st_q;
    pos_d = pos_q;
    col_d = col_q;
    row_d = row_q;
    k_d   = k_q;
    if (byte_acc) begin
      if (pos_q == PW'(CELLS - 1)) begin
        pos_d = '0;
        col_d = '0;
        row_d = '0;
      end else begin
        pos_d = pos_q + 1'b1;
        if (col_q == SW'(SIDE - 1)) begin
          col_d = '0;
          row_d = row_q + 1'b1;
        end else begin
          col_d = col_q + 1'b1;
        end
      end
    end
    if (flush_acc) begin
      pos_d = '0;
      col_d = '0;
      row_d = '0;
    end
    if (flush_acc || (s1_vld_q && s1_full_q)) begin
      st_d = ST_EMIT;
      k_d  = '0;
    end
    if (emit_issue) begin
      k_d = k_q + 1'b1;
      if (k_last) st_d = ST_RUN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= ST_RUN;
      pos_q    <= '0;
      col_q    <= '0;
      row_q    <= '0;
      k_q      <= '0;
      s1_vld_q <= 1'b0;
    end else begin
      st_q     <= st_d;
      pos_q    <= pos_d;
      col_q    <= col_d;
      row_q    <= row_d;
      k_q      <= k_d;
      s1_vld_q <= byte_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_acc) begin
      s1_col_q  <= col_q;
      s1_row_q  <= row_q;
      s1_pos_q  <= pos_q;
      s1_b_q    <= in_word_i.data_byte;
      s1_full_q <= pos_q == PW'(CELLS - 1);
    end
  end

  // pending word and output register
  always_comb begin
    pend_d = pend_q;
    if (move) pend_d = 1'b0;
    if (emit_issue || read_acc) pend_d = 1'b1;
  end

  always_comb begin
    case (pend_kind_q)
      KIND_COL:  pend_value = {{(SUM_W-LAYER_SUM_W){col_val[LAYER_SUM_W-1]}}, col_val};
      KIND_ROW:  pend_value = {{(SUM_W-LAYER_SUM_W){row_val[LAYER_SUM_W-1]}}, row_val};
      KIND_CELL: pend_value = pend_oob_q ? '0 : cell_val;
      default:   pend_value = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q    <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
      if (move) begin
        out_vld_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_issue) begin
      pend_kind_q <= k_is_col ? KIND_COL : KIND_ROW;
      pend_idx_q  <= k_is_col ? IDX_W'(k_q) : IDX_W'(k_row);
      pend_last_q <= k_last;
      pend_oob_q  <= 1'b0;
    end else if (read_acc) begin
      pend_kind_q <= KIND_CELL;
      pend_idx_q  <= in_word_i.cell_index;
      pend_last_q <= 1'b1;
      pend_oob_q  <= idx_oob;
    end
    if (move) begin
      out_q.sum_kind    <= pend_kind_q;
      out_q.sum_index   <= pend_idx_q;
      out_q.sum_value   <= pend_value;
      out_q.last_of_run <= pend_last_q;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

  a_full_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_vld_q && s1_full_q |=> st_q == ST_EMIT)
    else $error("completed layer did not start emit");

  a_emit_pos_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_EMIT |-> pos_q == '0 && col_q == '0 && row_q == '0)
    else $error("layer position not restarted during emit");

  a_no_byte_in_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ST_EMIT && k_q != '0 |-> !s1_vld_q)
    else $error("byte update overlaps emit sweep");

  a_last_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && out_q.last_of_run && out_q.sum_kind == KIND_ROW
      |-> out_q.sum_index == IDX_W'(SIDE - 1))
    else $error("emit run ended on wrong row");

  a_pos_coords: assert property (@(posedge clk_i) disable iff (!rst_ni)
    byte_acc |=> s1_pos_q == PW'(s1_row_q * SIDE + s1_col_q))
    else $error("cell position and row/column disagree");

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import brcs_pkg::*;

  localparam int SIDE        = SIDE_DEF;
  localparam int CELLS       = SIDE * SIDE;
  localparam int MAX_WAIT    = 17;
  localparam int CYCLE_LIMIT = 600000;
  localparam int TAIL_CYCLES = 30;
  localparam int RANDOM_WORDS = 84;
  localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_word_t  in_word_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_word_t out_word_o;

  block_row_column_sum_checksum dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  logic [LAYER_SUM_W-1:0] col_acc [SIDE];
  logic [LAYER_SUM_W-1:0] row_acc [SIDE];
  logic [SUM_W-1:0]       cell_acc [CELLS];
  int                     layer_pos;
  out_word_t              sums_due [$];

  bit idle_in;
  bit idle_out;
  int hold_cycles = 0;
  int mismatches = 0;
  int cycle_count = 0;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 50) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  function automatic logic [SUM_W-1:0] widen_layer_sum(input logic [LAYER_SUM_W-1:0] v);
    return {{(SUM_W-LAYER_SUM_W){v[LAYER_SUM_W-1]}}, v};
  endfunction

  function automatic void queue_layer();
    out_word_t w;
    for (int c = 0; c < SIDE; c++) begin
      w.sum_kind    = KIND_COL;
      w.sum_index   = IDX_W'(c);
      w.sum_value   = widen_layer_sum(col_acc[c]);
      w.last_of_run = 1'b0;
      sums_due.push_back(w);
    end
    for (int r = 0; r < SIDE; r++) begin
      w.sum_kind    = KIND_ROW;
      w.sum_index   = IDX_W'(r);
      w.sum_value   = widen_layer_sum(row_acc[r]);
      w.last_of_run = (r == SIDE - 1);
      sums_due.push_back(w);
    end
    for (int k = 0; k < SIDE; k++) begin
      col_acc[k] = '0;
      row_acc[k] = '0;
    end
    layer_pos = 0;
  endfunction

  function automatic void predict_sums(input in_word_t w);
    logic [SUM_W-1:0] ext;
    out_word_t        rd;
    case (w.action)
      ACT_BYTE: begin
        ext = {{(SUM_W-DATA_W){w.data_byte[DATA_W-1]}}, w.data_byte};
        col_acc[layer_pos % SIDE] += ext[LAYER_SUM_W-1:0];
        row_acc[layer_pos / SIDE] += ext[LAYER_SUM_W-1:0];
        cell_acc[layer_pos] += ext;
        layer_pos++;
        if (layer_pos == CELLS) queue_layer();
      end
      ACT_FLUSH: begin
        queue_layer();
      end
      ACT_READ: begin
        rd.sum_kind    = KIND_CELL;
        rd.sum_index   = w.cell_index;
        rd.sum_value   = (w.cell_index < CELLS) ? cell_acc[w.cell_index] : '0;
        rd.last_of_run = 1'b1;
        sums_due.push_back(rd);
      end
      default: begin
      end
    endcase
  endfunction

  function automatic in_word_t byte_word(input logic [DATA_W-1:0] d);
    in_word_t w;
    w.action     = ACT_BYTE;
    w.data_byte  = d;
    w.cell_index = IDX_W'($urandom);
    return w;
  endfunction

  function automatic in_word_t read_word(input logic [IDX_W-1:0] idx);
    in_word_t w;
    w.action     = ACT_READ;
    w.data_byte  = DATA_W'($urandom);
    w.cell_index = idx;
    return w;
  endfunction

  function automatic in_word_t other_word(input logic [ACT_W-1:0] act);
    in_word_t w;
    w.action     = act;
    w.data_byte  = DATA_W'($urandom);
    w.cell_index = IDX_W'($urandom);
    return w;
  endfunction

  // leaves valid high after the handshake so the next word can follow at once
  task automatic send_word(input in_word_t w);
    int gap;
    gap = idle_in ? $urandom_range(0, MAX_WAIT) : 0;
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    predict_sums(w);
  endtask

  task automatic finish_phase();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sums_due.size() != 0);
  endtask

  initial begin : receiver
    int wait_left;
    wait_left = 0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0)
        wait_left = idle_out ? $urandom_range(0, MAX_WAIT) : 0;
      if (hold_cycles > 0) begin
        hold_cycles--;
        out_stall_i <= 1'b1;
      end else if (wait_left > 0) begin
        wait_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : check_sums
    out_word_t want;
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      if (sums_due.size() == 0) begin
        report_mismatch($sformatf("unexpected word %h", out_word_o));
      end else begin
        want = sums_due.pop_front();
        if (out_word_o.sum_kind !== want.sum_kind)
          report_mismatch($sformatf("sum_kind got %0d want %0d",
                                    out_word_o.sum_kind, want.sum_kind));
        if (out_word_o.sum_index !== want.sum_index)
          report_mismatch($sformatf("sum_index got %0d want %0d",
                                    out_word_o.sum_index, want.sum_index));
        if (out_word_o.sum_value !== want.sum_value)
          report_mismatch($sformatf("sum_value got %0d want %0d (index %0d)",
                                    out_word_o.sum_value, want.sum_value, want.sum_index));
        if (out_word_o.last_of_run !== want.last_of_run)
          report_mismatch($sformatf("last_of_run got %0b want %0b (index %0d)",
                                    out_word_o.last_of_run, want.last_of_run,
                                    want.sum_index));
      end
    end
  end

  task automatic test_directed();
    idle_in  = 1'b1;
    idle_out = 1'b1;
    send_word(read_word(7'd0));
    send_word(read_word(IDX_W'(CELLS - 1)));
    send_word(read_word(IDX_W'(CELLS)));
    send_word(read_word(7'h7F));
    send_word(other_word(ACT_FLUSH));
    send_word(other_word(ACT_NONE));
    send_word(byte_word(8'h7F));
    send_word(byte_word(8'h80));
    send_word(byte_word(8'h00));
    send_word(byte_word(8'hFF));
    send_word(byte_word(8'h01));
    send_word(read_word(7'd0));
    send_word(read_word(7'd1));
    send_word(read_word(7'd4));
    send_word(other_word(ACT_NONE));
    send_word(byte_word(8'h55));
    send_word(other_word(ACT_FLUSH));
    send_word(read_word(7'd0));
    send_word(read_word(7'd5));
    send_word(byte_word(8'h80));
    send_word(read_word(7'd0));
    send_word(other_word(ACT_FLUSH));
  endtask

  // one full layer: upper rows at the top of the byte range, lower rows at the bottom
  task automatic test_layer_extremes();
    idle_in  = 1'b0;
    idle_out = 1'b1;
    for (int p = 0; p < CELLS; p++)
      send_word(byte_word((p < CELLS / 2) ? 8'h7F : 8'h80));
    idle_in = 1'b1;
    send_word(read_word(7'd0));
    send_word(read_word(IDX_W'(CELLS - 1)));
  endtask

  // receiver holds off while a flush drains, so the block backs up
  task automatic test_backpressure();
    idle_in  = 1'b0;
    idle_out = 1'b0;
    repeat (8) send_word(byte_word(DATA_W'($urandom)));
    hold_cycles = 300;
    send_word(other_word(ACT_FLUSH));
    repeat (12) send_word(read_word(IDX_W'($urandom_range(0, CELLS - 1))));
  endtask

  task automatic test_random();
    int  sent;
    int  pick;
    sent = 0;
    while (sent < RANDOM_WORDS) begin
      {idle_out, idle_in} = 2'($urandom_range(0, 3));
      repeat (12) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          send_word(byte_word(DATA_W'($urandom)));
        end else if (pick < 62) begin
          send_word(byte_word($urandom_range(0, 1) ? 8'h7F : 8'h80));
        end else if (pick < 78) begin
          send_word(read_word(IDX_W'($urandom_range(0, CELLS - 1))));
        end else if (pick < 84) begin
          send_word(read_word(IDX_W'($urandom_range(CELLS, 127))));
        end else if (pick < 94) begin
          send_word(other_word(ACT_FLUSH));
        end else begin
          send_word(other_word(ACT_NONE));
          sent--;
        end
        sent++;
      end
    end
  endtask

  initial begin
    rst_ni     <= 1'b0;
    in_valid_i <= 1'b0;
    in_word_i  <= '0;
    idle_in  = 1'b0;
    idle_out = 1'b0;
    for (int k = 0; k < SIDE; k++) begin
      col_acc[k] = '0;
      row_acc[k] = '0;
    end
    for (int k = 0; k < CELLS; k++) cell_acc[k] = '0;
    layer_pos = 0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    finish_phase();
    test_layer_extremes();
    finish_phase();
    test_backpressure();
    finish_phase();
    test_random();
    finish_phase();

    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && sums_due.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
